@@ src/pdc_pkg.sv @@
// ----------------------------------------------------------------------------
// pdc_pkg
// Shared types, register indexes and the CRC-16 byte update of the deframer.
// ----------------------------------------------------------------------------
package pdc_pkg;

   localparam int DATA_W = 8;
   localparam int LEN_W  = 7;
   localparam int CRC_W  = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
   localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

   localparam logic [DATA_W-1:0] START_RESET   = 8'hAA;
   localparam logic [DATA_W-1:0] END_RESET     = 8'h55;
   localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 7'd64;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_MARKER = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_MARKER   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LENGTH   = 2'd2;

   // descriptor queue
   localparam int DESC_DEPTH = 2;
   localparam int DESC_PTR_W = 1;
   localparam int DESC_CNT_W = 2;

   // one completed frame, as handed from parser to emitter
   typedef struct packed {
      logic              status;
      logic [DATA_W-1:0] command;
      logic [LEN_W-1:0]  length;
   } desc_type;

   // payload store write port
   typedef struct packed {
      logic              en;
      logic [LEN_W-1:0]  idx;
      logic [DATA_W-1:0] data;
   } wr_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_stat_type;

   // reflected CRC-16, LSB first, one byte
   function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                   input logic [DATA_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

@@ src/pdc_parser.sv @@
// ----------------------------------------------------------------------------
// pdc_parser
// Front end: holds the registers, hunts for frames, runs the CRC, writes the
// payload store and queues one descriptor per closed frame.
// ----------------------------------------------------------------------------
module pdc_parser #(
   parameter int PAYLOAD_DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [pdc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pdc_pkg::DATA_W-1:0]        csr_wdata,
   input  logic [pdc_pkg::DATA_W-1:0]        req_rx_byte,
   input  logic                              req_line_error,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic                              fifo_full,
   input  logic                              store_hold,
   output logic                              desc_push,
   output pdc_pkg::desc_type                 desc_out,
   output pdc_pkg::wr_type                   wr
);

   typedef enum logic [2:0] {
      PH_HUNT, PH_CMD, PH_LEN, PH_DATA, PH_CRCH, PH_CRCL, PH_ENDB
   } phase_type;

   phase_type                    phase_ff, phase_in;
   logic [pdc_pkg::DATA_W-1:0]   start_ff, end_ff;
   logic [pdc_pkg::LEN_W-1:0]    max_len_ff;
   logic [pdc_pkg::DATA_W-1:0]   cmd_ff, cmd_in;
   logic [pdc_pkg::LEN_W-1:0]    len_ff, len_in;
   logic [pdc_pkg::LEN_W-1:0]    idx_ff, idx_in;
   logic [pdc_pkg::CRC_W-1:0]    crc_ff, crc_in;
   logic [pdc_pkg::CRC_W-1:0]    rx_crc_ff, rx_crc_in;
   logic [pdc_pkg::CRC_W-1:0]    crc_next;
   logic [pdc_pkg::LEN_W-1:0]    idx_inc;
   logic                         act;
   logic                         len_ok;

   // payload bytes wait while the store still belongs to an earlier frame; the end byte waits while the queue is full
   assign req_full = ((phase_ff == PH_DATA) && store_hold) ||
                     ((phase_ff == PH_ENDB) && fifo_full);
   assign act      = req_push && !req_full && !req_line_error;
   assign crc_next = pdc_pkg::crc16_byte(crc_ff, req_rx_byte);
   assign idx_inc  = idx_ff + 7'd1;
   assign len_ok   = ({1'b0, req_rx_byte} <= {2'b00, max_len_ff}) &&
                     (9'(req_rx_byte) <= 9'(PAYLOAD_DEPTH));

   always_comb begin
      phase_in  = phase_ff;
      cmd_in    = cmd_ff;
      len_in    = len_ff;
      idx_in    = idx_ff;
      crc_in    = crc_ff;
      rx_crc_in = rx_crc_ff;
      desc_push = 1'b0;
      wr.en     = 1'b0;
      wr.idx    = idx_ff;
      wr.data   = req_rx_byte;
      if (act) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (req_rx_byte == start_ff) begin
                  crc_in   = pdc_pkg::CRC_INIT;
                  phase_in = PH_CMD;
               end
            end
            PH_CMD: begin
               cmd_in   = req_rx_byte;
               crc_in   = crc_next;
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               if (len_ok) begin
                  len_in   = req_rx_byte[pdc_pkg::LEN_W-1:0];
                  idx_in   = '0;
                  crc_in   = crc_next;
                  phase_in = (req_rx_byte != 8'd0) ? PH_DATA : PH_CRCH;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_DATA: begin
               wr.en  = 1'b1;
               crc_in = crc_next;
               idx_in = idx_inc;
               if (idx_inc >= len_ff) begin
                  phase_in = PH_CRCH;
               end
            end
            PH_CRCH: begin
               rx_crc_in = {req_rx_byte, 8'h00};
               phase_in  = PH_CRCL;
            end
            PH_CRCL: begin
               rx_crc_in = {rx_crc_ff[15:8], req_rx_byte};
               phase_in  = PH_ENDB;
            end
            PH_ENDB: begin
               desc_push = (req_rx_byte == end_ff);
               phase_in  = PH_HUNT;
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   assign desc_out.status  = (crc_ff != rx_crc_ff);
   assign desc_out.command = cmd_ff;
   assign desc_out.length  = len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         start_ff   <= pdc_pkg::START_RESET;
         end_ff     <= pdc_pkg::END_RESET;
         max_len_ff <= pdc_pkg::MAX_LEN_RESET;
         cmd_ff     <= '0;
         len_ff     <= '0;
         idx_ff     <= '0;
         crc_ff     <= pdc_pkg::CRC_INIT;
         rx_crc_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         cmd_ff    <= cmd_in;
         len_ff    <= len_in;
         idx_ff    <= idx_in;
         crc_ff    <= crc_in;
         rx_crc_ff <= rx_crc_in;
         if (csr_write_en) begin
            unique case (csr_index)
               pdc_pkg::CSR_START_MARKER: start_ff   <= csr_wdata;
               pdc_pkg::CSR_END_MARKER:   end_ff     <= csr_wdata;
               pdc_pkg::CSR_MAX_LENGTH:   max_len_ff <= csr_wdata[pdc_pkg::LEN_W-1:0];
               default: ;
            endcase
         end
      end
   end

endmodule

@@ src/pdc_desc_fifo.sv @@
// ----------------------------------------------------------------------------
// pdc_desc_fifo
// Short queue of frame descriptors between parser and emitter.
// ----------------------------------------------------------------------------
module pdc_desc_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  pdc_pkg::desc_type      push_desc,
   input  logic                   pop,
   output pdc_pkg::desc_type      head,
   output pdc_pkg::fifo_stat_type stat
);

   pdc_pkg::desc_type                 slot_ff [pdc_pkg::DESC_DEPTH];
   logic [pdc_pkg::DESC_PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [pdc_pkg::DESC_CNT_W-1:0]    count_ff;
   logic                              do_push, do_pop;

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == pdc_pkg::DESC_CNT_W'(pdc_pkg::DESC_DEPTH));
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head       = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (do_push && !do_pop) begin
            count_ff <= count_ff + pdc_pkg::DESC_CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - pdc_pkg::DESC_CNT_W'(1);
         end
      end
   end

endmodule

@@ src/pdc_emitter.sv @@
// ----------------------------------------------------------------------------
// pdc_emitter
// Back end: owns the payload store, takes descriptors and plays each frame
// out as results through an output register.
// ----------------------------------------------------------------------------
module pdc_emitter #(
   parameter int PAYLOAD_DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pdc_pkg::wr_type               wr,
   input  pdc_pkg::desc_type             head,
   input  logic                          desc_empty,
   output logic                          desc_pop,
   output logic                          busy,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic                          rsp_status,
   output logic [pdc_pkg::DATA_W-1:0]    rsp_command,
   output logic [pdc_pkg::LEN_W-1:0]     rsp_length,
   output logic [pdc_pkg::DATA_W-1:0]    rsp_payload_byte,
   output logic                          rsp_byte_valid,
   output logic                          rsp_last
);

   localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

   typedef enum logic [1:0] {E_IDLE, E_FETCH, E_LOAD} emit_type;

   emit_type                     state_ff;
   pdc_pkg::desc_type            cur_ff;
   logic [pdc_pkg::LEN_W-1:0]    idx_ff;
   logic [pdc_pkg::DATA_W-1:0]   mem [PAYLOAD_DEPTH];
   logic [pdc_pkg::DATA_W-1:0]   mem_q_ff;
   logic                         out_valid_ff;
   logic                         slot_free;
   logic                         load_out;
   logic                         single;
   logic                         is_last;
   logic [pdc_pkg::LEN_W-1:0]    idx_inc;

   assign slot_free = !out_valid_ff || rsp_pop;
   assign load_out  = (state_ff == E_LOAD) && slot_free;
   assign single    = cur_ff.status || (cur_ff.length == '0);
   assign idx_inc   = idx_ff + 7'd1;
   assign is_last   = (idx_inc == cur_ff.length);
   assign desc_pop  = (state_ff == E_IDLE) && !desc_empty;
   assign busy      = (state_ff != E_IDLE);
   assign rsp_empty = !out_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[AW'(wr.idx)] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == E_FETCH) begin
         mem_q_ff <= mem[AW'(idx_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= E_IDLE;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         // a new result replaces the popped one in the same cycle
         out_valid_ff <= load_out || (out_valid_ff && !rsp_pop);
         unique case (state_ff)
            E_IDLE: begin
               if (!desc_empty) begin
                  cur_ff <= head;
                  idx_ff <= '0;
                  state_ff <= (head.status || (head.length == '0)) ? E_LOAD : E_FETCH;
               end
            end
            E_FETCH: begin
               state_ff <= E_LOAD;
            end
            E_LOAD: begin
               if (slot_free) begin
                  rsp_status   <= cur_ff.status;
                  rsp_command  <= cur_ff.command;
                  rsp_length   <= cur_ff.length;
                  if (single) begin
                     rsp_payload_byte <= '0;
                     rsp_byte_valid   <= 1'b0;
                     rsp_last         <= 1'b1;
                     state_ff         <= E_IDLE;
                  end else begin
                     rsp_payload_byte <= mem_q_ff;
                     rsp_byte_valid   <= 1'b1;
                     rsp_last         <= is_last;
                     idx_ff           <= idx_inc;
                     state_ff         <= is_last ? E_IDLE : E_FETCH;
                  end
               end
            end
            default: begin
               state_ff <= E_IDLE;
            end
         endcase
      end
   end

endmodule

@@ src/packet_deframer_crc16.sv @@
// ----------------------------------------------------------------------------
// packet_deframer_crc16
// Byte-framed packet parser with CRC-16 check and payload replay.
// ----------------------------------------------------------------------------
// Received bytes enter through a push/full queue port, one item per cycle
// when full is low; bytes flagged with a line error are taken and dropped.
// A frame is start, command, length, payload, CRC high, CRC low, end. The
// CRC-16 (init FFFF, reflected poly A001) covers command, length and payload.
// On a correct end byte a good frame comes out as one result per payload
// byte (one result with byte_valid low for an empty frame), a bad CRC as a
// single error result; results leave through an empty/pop port. The emitter
// makes each payload result by a registered read of the payload store and
// then a load of the output register. Because the store is single,
// full rises on payload bytes while an earlier frame is still queued or
// being played out; the end byte also waits while two closed frames are
// already queued. Other bytes keep flowing. Up to two closed frames queue.
// ----------------------------------------------------------------------------
module packet_deframer_crc16 #(
   parameter int PAYLOAD_DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration
   input  logic                          csr_write_en,
   input  logic [pdc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pdc_pkg::DATA_W-1:0]    csr_wdata,
   // received bytes
   input  logic [pdc_pkg::DATA_W-1:0]    req_rx_byte,
   input  logic                          req_line_error,
   input  logic                          req_push,
   output logic                          req_full,
   // results
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic                          rsp_status,
   output logic [pdc_pkg::DATA_W-1:0]    rsp_command,
   output logic [pdc_pkg::LEN_W-1:0]     rsp_length,
   output logic [pdc_pkg::DATA_W-1:0]    rsp_payload_byte,
   output logic                          rsp_byte_valid,
   output logic                          rsp_last
);

   pdc_pkg::desc_type      desc_in, desc_head;
   pdc_pkg::fifo_stat_type fifo_stat;
   pdc_pkg::wr_type        wr;
   logic                   desc_push, desc_pop;
   logic                   emit_busy;
   logic                   store_hold;

   // store is free only with nothing queued and the emitter idle
   assign store_hold = !fifo_stat.empty || emit_busy;

   pdc_parser #(
      .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
   ) u_parser (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_rx_byte    (req_rx_byte),
      .req_line_error (req_line_error),
      .req_push       (req_push),
      .req_full       (req_full),
      .fifo_full      (fifo_stat.full),
      .store_hold     (store_hold),
      .desc_push      (desc_push),
      .desc_out       (desc_in),
      .wr             (wr)
   );

   pdc_desc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (desc_push),
      .push_desc (desc_in),
      .pop       (desc_pop),
      .head      (desc_head),
      .stat      (fifo_stat)
   );

   pdc_emitter #(
      .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
   ) u_emitter (
      .clock            (clock),
      .reset            (reset),
      .wr               (wr),
      .head             (desc_head),
      .desc_empty       (fifo_stat.empty),
      .desc_pop         (desc_pop),
      .busy             (emit_busy),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_status       (rsp_status),
      .rsp_command      (rsp_command),
      .rsp_length       (rsp_length),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_last         (rsp_last)
   );

endmodule

@@ src/pdc_checker.sv @@
// ----------------------------------------------------------------------------
// pdc_checker
// Port-level checks on the deframer result stream, bound to the top level.
// ----------------------------------------------------------------------------
module pdc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_empty,
   input logic                          rsp_pop,
   input logic                          rsp_status,
   input logic [pdc_pkg::DATA_W-1:0]    rsp_command,
   input logic [pdc_pkg::LEN_W-1:0]     rsp_length,
   input logic [pdc_pkg::DATA_W-1:0]    rsp_payload_byte,
   input logic                          rsp_byte_valid,
   input logic                          rsp_last
);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result present straight after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_payload_byte) &&
         $stable(rsp_last) && $stable(rsp_status) && $stable(rsp_command) &&
         $stable(rsp_length) && $stable(rsp_byte_valid)))
      else $error("stalled result changed");

   a_nodata_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_byte_valid) |-> rsp_last)
      else $error("result without data is not the final one");

   a_err_nodata: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status) |-> (!rsp_byte_valid && rsp_payload_byte == '0))
      else $error("error result carries data");

   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_byte_valid) |-> (rsp_length != '0))
      else $error("data result from an empty frame");

endmodule

bind packet_deframer_crc16 pdc_checker u_pdc_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_empty        (rsp_empty),
   .rsp_pop          (rsp_pop),
   .rsp_status       (rsp_status),
   .rsp_command      (rsp_command),
   .rsp_length       (rsp_length),
   .rsp_payload_byte (rsp_payload_byte),
   .rsp_byte_valid   (rsp_byte_valid),
   .rsp_last         (rsp_last)
);
